// ===== rtl/zrg_pkg.sv =====
// Shared types and constants for the zone request generator.
// No dependencies; imported by zrg_update, zone_request_generator and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package zrg_pkg;

  localparam int ZONES_DEFAULT = 64;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 7;
  localparam logic [CFG_IDX_W-1:0] REG_UNITS_IMPERIAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ZONES   = 1'b1;
  localparam logic [6:0] ACTIVE_ZONES_RESET = 7'd64;

  // timing and level thresholds (ms, 0.1 %)
  localparam logic [15:0] PRESS_PERSIST_MS = 16'd60000;
  localparam logic [15:0] SUPPRESS_MS      = 16'd60000;
  localparam logic [16:0] TEMP_PERSIST_MS  = 17'd120000;
  localparam logic [9:0]  ON_LEVEL         = 10'd950;
  localparam logic [9:0]  OFF_LEVEL        = 10'd850;

  // temperature excess thresholds, 0.01 degree
  localparam logic signed [16:0] HIGH_C = 17'sd300;
  localparam logic signed [16:0] MED_C  = 17'sd200;
  localparam logic signed [16:0] HIGH_F = 17'sd500;
  localparam logic signed [16:0] MED_F  = 17'sd300;

  // request levels
  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_ONE  = 2'd1;
  localparam logic [1:0] REQ_TWO  = 2'd2;
  localparam logic [1:0] REQ_THREE = 2'd3;

  // one memory word per zone
  typedef struct packed {
    logic [15:0] press_high_timer;
    logic [15:0] press_med_timer;
    logic [1:0]  press_last_request;
    logic [16:0] temp_high_timer;
    logic [16:0] temp_med_timer;
    logic [15:0] suppress_timer;
    logic [1:0]  temp_last_request;
  } zone_state_t;

  typedef struct packed {
    logic [15:0] zone_temp;
    logic [15:0] cooling_setpoint;
    logic [9:0]  cooling_demand;
    logic [15:0] airflow;
    logic [15:0] airflow_setpoint;
    logic [9:0]  damper_command;
    logic [15:0] elapsed_ms;
  } sample_t;

  typedef struct packed {
    logic [1:0] pressure_requests;
    logic [1:0] cooling_requests;
  } requests_t;

endpackage

`default_nettype wire

// ===== rtl/zrg_update.sv =====
// Per-zone state update: next timers and last requests plus request counts.
// Purely combinational; uses zrg_pkg types and thresholds.
`timescale 1ns / 1ps
`default_nettype none

module zrg_update (
  input  wire logic              units_imperial,
  input  wire zrg_pkg::sample_t  sample,
  input  wire zrg_pkg::zone_state_t cur,
  output zrg_pkg::zone_state_t   nxt,
  output zrg_pkg::requests_t     req
);
  import zrg_pkg::*;

  logic        open_wide;
  logic        low50;
  logic        low70;
  logic [19:0] flow_x10;
  logic [19:0] sp_x7;
  logic [16:0] ph_sum;
  logic [16:0] pm_sum;
  logic [15:0] ph_sat;
  logic [15:0] pm_sat;
  logic [15:0] ph_new;
  logic [15:0] pm_new;

  logic signed [16:0] diff;
  logic signed [16:0] high_lvl;
  logic signed [16:0] med_lvl;
  logic [16:0] st_sum;
  logic [15:0] st_new;
  logic [17:0] th_sum;
  logic [17:0] tm_sum;
  logic [16:0] th_sat;
  logic [16:0] tm_sat;

  assign open_wide = sample.damper_command >= ON_LEVEL;
  assign low50     = {sample.airflow, 1'b0} < {1'b0, sample.airflow_setpoint};
  assign flow_x10  = 20'(sample.airflow) * 20'd10;
  assign sp_x7     = 20'(sample.airflow_setpoint) * 20'd7;
  assign low70     = flow_x10 < sp_x7;

  assign ph_sum = {1'b0, cur.press_high_timer} + {1'b0, sample.elapsed_ms};
  assign pm_sum = {1'b0, cur.press_med_timer} + {1'b0, sample.elapsed_ms};
  assign ph_sat = ph_sum[16] ? 16'hFFFF : ph_sum[15:0];
  assign pm_sat = pm_sum[16] ? 16'hFFFF : pm_sum[15:0];
  assign ph_new = (open_wide && low50) ? ph_sat : 16'd0;
  assign pm_new = (open_wide && low70) ? pm_sat : 16'd0;

  assign diff = $signed({sample.zone_temp[15], sample.zone_temp})
              - $signed({sample.cooling_setpoint[15], sample.cooling_setpoint});
  assign high_lvl = units_imperial ? HIGH_F : HIGH_C;
  assign med_lvl  = units_imperial ? MED_F : MED_C;

  // suppression timer only advances until it reaches its cap
  assign st_sum = {1'b0, cur.suppress_timer} + {1'b0, sample.elapsed_ms};
  assign st_new = (cur.suppress_timer >= SUPPRESS_MS) ? cur.suppress_timer :
                  (st_sum > {1'b0, SUPPRESS_MS}) ? SUPPRESS_MS : st_sum[15:0];

  assign th_sum = {1'b0, cur.temp_high_timer} + 18'(sample.elapsed_ms);
  assign tm_sum = {1'b0, cur.temp_med_timer} + 18'(sample.elapsed_ms);
  assign th_sat = th_sum[17] ? 17'h1FFFF : th_sum[16:0];
  assign tm_sat = tm_sum[17] ? 17'h1FFFF : tm_sum[16:0];

  always_comb begin
    nxt = cur;
    req = '0;

    // static pressure
    if (sample.airflow_setpoint == 16'd0) begin
      nxt.press_high_timer   = 16'd0;
      nxt.press_med_timer    = 16'd0;
      nxt.press_last_request = REQ_NONE;
      req.pressure_requests  = REQ_NONE;
    end else begin
      nxt.press_high_timer = ph_new;
      if (ph_new >= PRESS_PERSIST_MS) begin
        nxt.press_med_timer    = 16'd0;
        nxt.press_last_request = REQ_THREE;
        req.pressure_requests  = REQ_THREE;
      end else begin
        nxt.press_med_timer = pm_new;
        if (pm_new >= PRESS_PERSIST_MS) begin
          nxt.press_last_request = REQ_TWO;
          req.pressure_requests  = REQ_TWO;
        end else if (open_wide) begin
          nxt.press_last_request = REQ_ONE;
          req.pressure_requests  = REQ_ONE;
        end else if (cur.press_last_request == REQ_ONE &&
                     sample.damper_command >= OFF_LEVEL) begin
          req.pressure_requests = REQ_ONE;
        end else begin
          nxt.press_last_request = REQ_NONE;
          req.pressure_requests  = REQ_NONE;
        end
      end
    end

    // cooling
    nxt.suppress_timer  = st_new;
    nxt.temp_high_timer = 17'd0;
    nxt.temp_med_timer  = 17'd0;
    if (st_new >= SUPPRESS_MS) begin
      if (diff >= high_lvl) begin
        nxt.temp_high_timer = th_sat;
      end else if (diff >= med_lvl) begin
        nxt.temp_med_timer = tm_sat;
      end
    end

    if (nxt.temp_high_timer >= TEMP_PERSIST_MS) begin
      nxt.temp_last_request = REQ_THREE;
      req.cooling_requests  = REQ_THREE;
    end else if (nxt.temp_med_timer >= TEMP_PERSIST_MS) begin
      nxt.temp_last_request = REQ_TWO;
      req.cooling_requests  = REQ_TWO;
    end else if (sample.cooling_demand >= ON_LEVEL) begin
      nxt.temp_last_request = REQ_ONE;
      req.cooling_requests  = REQ_ONE;
    end else if (cur.temp_last_request == REQ_ONE &&
                 sample.cooling_demand >= OFF_LEVEL) begin
      req.cooling_requests = REQ_ONE;
    end else begin
      nxt.temp_last_request = REQ_NONE;
      req.cooling_requests  = REQ_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/zone_request_generator.sv =====
// Top level of the zone request generator: state memory, pipeline, config.
// Depends on zrg_pkg and zrg_update.
`timescale 1ns / 1ps
`default_nettype none

// Takes one zone sample per cycle while in_ready is high and returns one
// result per sample through the update stage and the output registers.
// Per-zone timers and last requests live in one synchronous RAM of ZONES
// words (one read port used at input transfer, one write port used when the
// result leaves the update stage); a same-zone sample taken as that result
// leaves gets the freshly computed state forwarded. After reset the RAM is
// cleared one zone per cycle, with in_ready low until all zones are cleared;
// configuration writes are taken then. A zone at or above active_zones (or
// ZONES) returns accepted = 0 with zero requests and leaves all state alone.
module zone_request_generator #(
  parameter int ZONES = zrg_pkg::ZONES_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [zrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [zrg_pkg::CFG_W-1:0]    cfg_data,
  // sample channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [5:0]                   zone,
  input  wire logic signed [15:0]           zone_temp,
  input  wire logic signed [15:0]           cooling_setpoint,
  input  wire logic [9:0]                   cooling_demand,
  input  wire logic [15:0]                  airflow,
  input  wire logic [15:0]                  airflow_setpoint,
  input  wire logic [9:0]                   damper_command,
  input  wire logic [15:0]                  elapsed_ms,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [5:0]                        zone_out,
  output logic                              accepted,
  output logic [1:0]                        pressure_requests,
  output logic [1:0]                        cooling_requests
);
  import zrg_pkg::*;

  localparam int IDX_W = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ZONES - 1);

  // configuration registers
  logic       units_imperial;
  logic [6:0] active_zones;

  // clearing pass
  logic             clearing;
  logic [IDX_W-1:0] clr_addr;

  // state memory
  zone_state_t mem [ZONES];
  zone_state_t rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  zone_state_t      mem_wdata;

  // update stage
  logic        s1_valid;
  logic [5:0]  s1_zone;
  sample_t     s1_sample;
  logic        s1_fwd;
  zone_state_t fwd_entry;
  zone_state_t cur_entry;
  zone_state_t nxt_entry;
  requests_t   req;
  logic        s1_ok;
  logic        s1_go;
  logic        upd_we;
  logic        in_xfer;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clearing && (!s1_valid || s1_go);
  assign in_xfer  = in_valid && in_ready;

  assign s1_ok  = ({1'b0, s1_zone} < active_zones) && (32'(s1_zone) < 32'(ZONES));
  assign upd_we = s1_go && s1_ok;

  assign cur_entry = s1_fwd ? fwd_entry : rdata;

  zrg_update u_update (
    .units_imperial (units_imperial),
    .sample         (s1_sample),
    .cur            (cur_entry),
    .nxt            (nxt_entry),
    .req            (req)
  );

  assign mem_we    = clearing || upd_we;
  assign mem_waddr = clearing ? clr_addr : IDX_W'(s1_zone);
  assign mem_wdata = clearing ? zone_state_t'('0) : nxt_entry;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_xfer) begin
      rdata <= mem[IDX_W'(zone)];
    end
  end

  // sample, forwarding and output registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_zone   <= zone;
      s1_sample <= '{zone_temp, cooling_setpoint, cooling_demand, airflow,
                     airflow_setpoint, damper_command, elapsed_ms};
      // RAM read races the write of the same zone at this edge
      s1_fwd    <= upd_we && (zone == s1_zone);
      fwd_entry <= nxt_entry;
    end
    if (s1_go) begin
      zone_out          <= s1_zone;
      accepted          <= s1_ok;
      pressure_requests <= s1_ok ? req.pressure_requests : REQ_NONE;
      cooling_requests  <= s1_ok ? req.cooling_requests : REQ_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      units_imperial <= 1'b0;
      active_zones   <= ACTIVE_ZONES_RESET;
      clearing       <= 1'b1;
      clr_addr       <= '0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_UNITS_IMPERIAL: units_imperial <= cfg_data[0];
          REG_ACTIVE_ZONES:   active_zones   <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST_IDX) begin
          clearing <= 1'b0;
        end
      end
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/zrg_checker.sv =====
// Port-level assertions for the zone request generator, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module zrg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] zone_out,
  input wire logic       accepted,
  input wire logic [1:0] pressure_requests,
  input wire logic [1:0] cooling_requests
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(zone_out) && $stable(accepted)
      && $stable(pressure_requests) && $stable(cooling_requests))
    else $error("result changed while stalled");

  // a rejected zone never raises requests
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> pressure_requests == 2'd0 && cooling_requests == 2'd0)
    else $error("rejected zone reported requests");

  // memory clear follows reset, no samples taken then
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block ready right after reset");

endmodule

bind zone_request_generator zrg_checker u_zrg_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for zone_request_generator: directed table, then random phases.
// Depends on zrg_pkg and the RTL of zone_request_generator.
`timescale 1ns / 1ps

module testbench;
  import zrg_pkg::*;

  localparam int NZ          = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_PHASES    = 6;

  // random phases: units, active zones, samples, idling on
  localparam int PH_UNITS[N_PHASES]  = '{1, 0, 1, 0, 1, 0};
  localparam int PH_ZONES[N_PHASES]  = '{64, 0, 1, 37, 127, 64};
  localparam int PH_ITEMS[N_PHASES]  = '{200, 20, 80, 200, 150, 150};
  localparam int PH_STALLS[N_PHASES] = '{1, 1, 1, 0, 1, 0};

  typedef struct packed {
    logic [5:0]  zone;
    logic [15:0] zone_temp;
    logic [15:0] cooling_setpoint;
    logic [9:0]  cooling_demand;
    logic [15:0] airflow;
    logic [15:0] airflow_setpoint;
    logic [9:0]  damper_command;
    logic [15:0] elapsed_ms;
  } zone_sample_t;

  typedef struct packed {
    logic [5:0] zone;
    logic       accepted;
    logic [1:0] press;
    logic [1:0] cool;
  } zone_result_t;

  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    zone_sample_t         smp;
    bit                   known;
    zone_result_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [5:0] zone;
  logic signed [15:0] zone_temp;
  logic signed [15:0] cooling_setpoint;
  logic [9:0] cooling_demand;
  logic [15:0] airflow;
  logic [15:0] airflow_setpoint;
  logic [9:0] damper_command;
  logic [15:0] elapsed_ms;
  logic out_valid;
  logic out_ready;
  logic [5:0] zone_out;
  logic accepted;
  logic [1:0] pressure_requests;
  logic [1:0] cooling_requests;

  zone_request_generator i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .zone, .zone_temp, .cooling_setpoint, .cooling_demand,
    .airflow, .airflow_setpoint, .damper_command, .elapsed_ms,
    .out_valid, .out_ready, .zone_out, .accepted, .pressure_requests, .cooling_requests
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // per-zone request state as the block should hold it
  logic [15:0] flow_high_ms[NZ];
  logic [15:0] flow_med_ms[NZ];
  logic [1:0]  flow_last_req[NZ];
  logic [16:0] temp_high_ms[NZ];
  logic [16:0] temp_med_ms[NZ];
  logic [15:0] startup_ms[NZ];
  logic [1:0]  temp_last_req[NZ];
  bit          units_f;
  int unsigned zone_limit;

  zone_result_t pending_results[$];
  stim_row_t    stimulus_table[$];
  bit           stalls_on;
  int           error_count;
  int           cycles;
  int           checked_results;
  int           samples_sent;
  int           settings_used;
  int           press_seen[4];
  int           cool_seen[4];

  function automatic int unsigned sat_sum(int unsigned a, int unsigned b, int unsigned lim);
    return (a + b > lim) ? lim : a + b;
  endfunction

  function automatic logic [1:0] pressure_level(int z, zone_sample_t s);
    bit          wide;
    int unsigned f;
    int unsigned sp;
    f    = s.airflow;
    sp   = s.airflow_setpoint;
    wide = s.damper_command >= ON_LEVEL;
    if (sp == 0) begin
      flow_high_ms[z]  = '0;
      flow_med_ms[z]   = '0;
      flow_last_req[z] = REQ_NONE;
      return REQ_NONE;
    end
    if (wide && 2 * f < sp) flow_high_ms[z] = 16'(sat_sum(flow_high_ms[z], s.elapsed_ms, 65535));
    else flow_high_ms[z] = '0;
    if (flow_high_ms[z] >= PRESS_PERSIST_MS) begin
      flow_med_ms[z]   = '0;
      flow_last_req[z] = REQ_THREE;
      return REQ_THREE;
    end
    if (wide && 10 * f < 7 * sp) flow_med_ms[z] = 16'(sat_sum(flow_med_ms[z], s.elapsed_ms, 65535));
    else flow_med_ms[z] = '0;
    if (flow_med_ms[z] >= PRESS_PERSIST_MS) begin
      flow_last_req[z] = REQ_TWO;
      return REQ_TWO;
    end
    if (wide) begin
      flow_last_req[z] = REQ_ONE;
      return REQ_ONE;
    end
    if (flow_last_req[z] == REQ_ONE && s.damper_command >= OFF_LEVEL) return REQ_ONE;
    flow_last_req[z] = REQ_NONE;
    return REQ_NONE;
  endfunction

  function automatic logic [1:0] cooling_level(int z, zone_sample_t s);
    int excess;
    int hi;
    int md;
    excess = int'($signed(s.zone_temp)) - int'($signed(s.cooling_setpoint));
    hi     = units_f ? int'(HIGH_F) : int'(HIGH_C);
    md     = units_f ? int'(MED_F) : int'(MED_C);
    if (startup_ms[z] < SUPPRESS_MS)
      startup_ms[z] = 16'(sat_sum(startup_ms[z], s.elapsed_ms, SUPPRESS_MS));
    if (startup_ms[z] >= SUPPRESS_MS) begin
      if (excess >= hi) begin
        temp_high_ms[z] = 17'(sat_sum(temp_high_ms[z], s.elapsed_ms, 131071));
        temp_med_ms[z]  = '0;
      end else if (excess >= md) begin
        temp_med_ms[z]  = 17'(sat_sum(temp_med_ms[z], s.elapsed_ms, 131071));
        temp_high_ms[z] = '0;
      end else begin
        temp_high_ms[z] = '0;
        temp_med_ms[z]  = '0;
      end
      if (temp_high_ms[z] >= TEMP_PERSIST_MS) begin
        temp_last_req[z] = REQ_THREE;
        return REQ_THREE;
      end
      if (temp_med_ms[z] >= TEMP_PERSIST_MS) begin
        temp_last_req[z] = REQ_TWO;
        return REQ_TWO;
      end
    end else begin
      temp_high_ms[z] = '0;
      temp_med_ms[z]  = '0;
    end
    if (s.cooling_demand >= ON_LEVEL) begin
      temp_last_req[z] = REQ_ONE;
      return REQ_ONE;
    end
    if (temp_last_req[z] == REQ_ONE && s.cooling_demand >= OFF_LEVEL) return REQ_ONE;
    temp_last_req[z] = REQ_NONE;
    return REQ_NONE;
  endfunction

  function automatic zone_result_t predict_requests(zone_sample_t s);
    zone_result_t r;
    r.zone     = s.zone;
    r.accepted = 1'b0;
    r.press    = REQ_NONE;
    r.cool     = REQ_NONE;
    if (s.zone < zone_limit) begin
      r.accepted = 1'b1;
      r.press    = pressure_level(int'(s.zone), s);
      r.cool     = cooling_level(int'(s.zone), s);
    end
    return r;
  endfunction

  function automatic void add_sample(int z, int temp, int spt, int demand, int flow,
                                     int flow_sp, int damper, int dt);
    stim_row_t row;
    row = '0;
    row.smp.zone             = 6'(z);
    row.smp.zone_temp        = 16'(temp);
    row.smp.cooling_setpoint = 16'(spt);
    row.smp.cooling_demand   = 10'(demand);
    row.smp.airflow          = 16'(flow);
    row.smp.airflow_setpoint = 16'(flow_sp);
    row.smp.damper_command   = 10'(damper);
    row.smp.elapsed_ms       = 16'(dt);
    stimulus_table.push_back(row);
  endfunction

  // attach an obvious expectation to the last sample
  function automatic void add_known(logic acc, logic [1:0] p, logic [1:0] c);
    stim_row_t row;
    row = stimulus_table.pop_back();
    row.known         = 1'b1;
    row.want.zone     = row.smp.zone;
    row.want.accepted = acc;
    row.want.press    = p;
    row.want.cool     = c;
    stimulus_table.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    stim_row_t row;
    row = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = CFG_W'(val);
    stimulus_table.push_back(row);
  endfunction

  function automatic int pick_level();
    case ($urandom_range(0, 11))
      0: return 849;
      1: return 850;
      2: return 851;
      3: return 949;
      4: return 950;
      5: return 951;
      6: return 1000;
      7: return 1023;
      default: return int'($urandom_range(0, 1023));
    endcase
  endfunction

  // mostly a few busy zones with long gaps so the timers actually ramp
  function automatic zone_sample_t random_sample();
    zone_sample_t s;
    int unsigned  sp;
    int unsigned  k;
    int unsigned  r;
    int           spt;
    int           excess;
    int           z;
    r = $urandom_range(0, 19);
    if (r < 12) z = int'($urandom_range(0, 3));
    else if (r < 16) begin
      z = (zone_limit == 0) ? 0 : int'(zone_limit) - 1 + int'($urandom_range(0, 1));
      if (z > NZ - 1) z = NZ - 1;
    end else z = int'($urandom_range(0, NZ - 1));
    s.zone = 6'(z);

    r = $urandom_range(0, 9);
    if (r < 4) s.elapsed_ms = 16'($urandom_range(30000, 65535));
    else if (r < 8) s.elapsed_ms = 16'($urandom_range(0, 5000));
    else s.elapsed_ms = 16'($urandom_range(0, 65535));

    s.damper_command = 10'(pick_level());
    s.cooling_demand = 10'(pick_level());

    case ($urandom_range(0, 9))
      0: begin
        sp = 0;
        s.airflow = 16'($urandom_range(0, 65535));
      end
      1: begin  // ratio exactly 0.7
        k = $urandom_range(1, 6553);
        sp = 10 * k;
        s.airflow = 16'(7 * k);
      end
      2: begin  // ratio exactly 0.5
        sp = 2 * $urandom_range(1, 32767);
        s.airflow = 16'(sp / 2);
      end
      3, 4: begin
        sp = $urandom_range(1, 65535);
        s.airflow = 16'($urandom_range(0, (sp - 1) / 2));
      end
      5, 6: begin
        sp = $urandom_range(1, 65535);
        s.airflow = 16'($urandom_range(sp / 2, (7 * sp - 1) / 10));
      end
      7, 8: begin
        sp = $urandom_range(1, 65535);
        s.airflow = 16'($urandom_range(7 * sp / 10, 65535));
      end
      default: begin
        sp = $urandom_range(0, 65535);
        s.airflow = 16'($urandom_range(0, 65535));
      end
    endcase
    s.airflow_setpoint = 16'(sp);

    if ($urandom_range(0, 9) < 8) begin
      spt = int'($urandom_range(0, 6000)) - 3000;
      case ($urandom_range(0, 7))
        0: excess = 199;
        1: excess = 200;
        2: excess = 299;
        3: excess = 300;
        4: excess = 499;
        5: excess = 500;
        default: excess = int'($urandom_range(0, 3000)) - 1500;
      endcase
      s.cooling_setpoint = 16'(spt);
      s.zone_temp        = 16'(spt + excess);
    end else begin
      s.cooling_setpoint = 16'($urandom_range(0, 65535));
      s.zone_temp        = 16'($urandom_range(0, 65535));
    end
    return s;
  endfunction

  task automatic push_sample(zone_sample_t s, bit known, zone_result_t want);
    zone_result_t r;
    @(negedge clk);
    in_valid         <= 1'b1;
    zone             <= s.zone;
    zone_temp        <= s.zone_temp;
    cooling_setpoint <= s.cooling_setpoint;
    cooling_demand   <= s.cooling_demand;
    airflow          <= s.airflow;
    airflow_setpoint <= s.airflow_setpoint;
    damper_command   <= s.damper_command;
    elapsed_ms       <= s.elapsed_ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_requests(s);
    pending_results.push_back(known ? want : r);
    samples_sent++;
  endtask

  task automatic sender_gap();
    if (stalls_on && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
  endtask

  // drop valid and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_UNITS_IMPERIAL) units_f = val[0];
    else zone_limit = val;
    settings_used++;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    zone_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer for zone %0d", zone_out);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("zone_out", want.zone, zone_out);
        check_field("accepted", want.accepted, accepted);
        check_field("pressure_requests", want.press, pressure_requests);
        check_field("cooling_requests", want.cool, cooling_requests);
        checked_results++;
        press_seen[pressure_requests]++;
        cool_seen[cooling_requests]++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : sink_pacing
    int n;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 8);
        out_ready <= 1'b0;
        repeat (n - 1) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : main
    stim_row_t    row;
    zone_sample_t s;
    int           ph;
    int           i;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    zone = '0;
    zone_temp = '0;
    cooling_setpoint = '0;
    cooling_demand = '0;
    airflow = '0;
    airflow_setpoint = '0;
    damper_command = '0;
    elapsed_ms = '0;
    stalls_on = 1'b0;
    error_count = 0;
    cycles = 0;
    checked_results = 0;
    samples_sent = 0;
    settings_used = 0;
    units_f = 1'b0;
    zone_limit = ACTIVE_ZONES_RESET;
    for (i = 0; i < 4; i++) begin
      press_seen[i] = 0;
      cool_seen[i] = 0;
    end
    for (i = 0; i < NZ; i++) begin
      flow_high_ms[i] = '0;
      flow_med_ms[i] = '0;
      flow_last_req[i] = REQ_NONE;
      temp_high_ms[i] = '0;
      temp_med_ms[i] = '0;
      startup_ms[i] = '0;
      temp_last_req[i] = REQ_NONE;
    end

    // reset settings: Celsius, all zones active
    add_sample(0, 0, 0, 0, 0, 0, 0, 0);
    add_known(1'b1, REQ_NONE, REQ_NONE);
    add_sample(63, 32767, -32768, 1023, 65535, 65535, 1023, 65535);
    add_known(1'b1, REQ_ONE, REQ_ONE);
    add_sample(63, 32767, -32768, 1023, 65535, 65535, 1023, 65535);
    add_known(1'b1, REQ_ONE, REQ_THREE);
    add_sample(63, 32767, -32768, 1023, 65535, 65535, 1023, 65535);
    add_known(1'b1, REQ_ONE, REQ_THREE);
    add_sample(63, -32768, 32767, 0, 0, 65535, 0, 65535);
    add_known(1'b1, REQ_NONE, REQ_NONE);
    add_sample(1, 0, 0, 0, 0, 100, 950, 60000);
    add_known(1'b1, REQ_THREE, REQ_NONE);
    add_sample(2, 0, 0, 0, 60, 100, 1000, 60000);
    add_known(1'b1, REQ_TWO, REQ_NONE);
    // damper and demand hysteresis
    add_sample(3, 0, 0, 950, 100, 100, 950, 10);
    add_known(1'b1, REQ_ONE, REQ_ONE);
    add_sample(3, 0, 0, 850, 100, 100, 850, 10);
    add_known(1'b1, REQ_ONE, REQ_ONE);
    add_sample(3, 0, 0, 849, 100, 100, 849, 10);
    add_known(1'b1, REQ_NONE, REQ_NONE);
    add_sample(3, 0, 0, 900, 100, 100, 900, 10);
    add_known(1'b1, REQ_NONE, REQ_NONE);
    // zero airflow setpoint wipes the pressure timers
    add_sample(1, 0, 0, 0, 0, 0, 950, 100);
    add_known(1'b1, REQ_NONE, REQ_NONE);
    add_sample(1, 0, 0, 0, 0, 100, 950, 100);
    add_known(1'b1, REQ_ONE, REQ_NONE);
    // ratio exactly 0.5 and exactly 0.7
    add_sample(5, 0, 0, 0, 50, 100, 950, 60000);
    add_sample(6, 0, 0, 0, 70, 100, 950, 60000);
    // medium and high excess, then just below the high threshold
    add_sample(4, 2200, 2000, 0, 100, 100, 0, 60000);
    add_sample(4, 2200, 2000, 0, 100, 100, 0, 60000);
    add_sample(7, 2300, 2000, 0, 100, 100, 0, 65535);
    add_sample(7, 2300, 2000, 0, 100, 100, 0, 65535);
    add_sample(7, 2299, 2000, 0, 100, 100, 0, 65535);
    // Fahrenheit thresholds, five active zones
    add_cfg(REG_UNITS_IMPERIAL, 1);
    add_cfg(REG_ACTIVE_ZONES, 5);
    add_sample(5, 2300, 2000, 1000, 0, 100, 1000, 60000);
    add_known(1'b0, REQ_NONE, REQ_NONE);
    add_sample(63, 2300, 2000, 1000, 0, 100, 1000, 60000);
    add_known(1'b0, REQ_NONE, REQ_NONE);
    add_sample(4, 2300, 2000, 0, 100, 100, 0, 60000);
    add_sample(4, 2499, 2000, 0, 100, 100, 0, 60000);
    add_sample(4, 2500, 2000, 0, 100, 100, 0, 60000);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    stalls_on = 1'b1;
    foreach (stimulus_table[i]) begin
      row = stimulus_table[i];
      if (row.is_cfg) begin
        drain_results();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        sender_gap();
        push_sample(row.smp, row.known, row.want);
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      write_reg(REG_UNITS_IMPERIAL, CFG_W'(PH_UNITS[ph]));
      write_reg(REG_ACTIVE_ZONES, CFG_W'(PH_ZONES[ph]));
      stalls_on = PH_STALLS[ph] != 0;
      for (i = 0; i < PH_ITEMS[ph]; i++) begin
        if ($urandom_range(0, 149) == 0) drain_results();
        sender_gap();
        s = random_sample();
        push_sample(s, 1'b0, '0);
      end
    end

    stalls_on = 1'b0;
    drain_results();
    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d samples over %0d register writes.",
             checked_results, samples_sent, settings_used);
    $display("Pressure levels 0..3 seen %0d/%0d/%0d/%0d, cooling levels %0d/%0d/%0d/%0d.",
             press_seen[0], press_seen[1], press_seen[2], press_seen[3],
             cool_seen[0], cool_seen[1], cool_seen[2], cool_seen[3]);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
